// ----- rtl/billboard_sprite_projection_defines.svh -----
// assertion macros for the billboard sprite projection block
`ifndef BILLBOARD_SPRITE_PROJECTION_DEFINES_SVH
`define BILLBOARD_SPRITE_PROJECTION_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BSP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BSP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSP_ASSERT(label, clk, rst_n, prop, msg)
`define BSP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- rtl/bsp_pkg.sv -----
`timescale 1ns / 1ps
package bsp_pkg;

  localparam int TEX_W        = 64;
  localparam int TEX_H        = 64;
  localparam int FRAMES_KIND0 = 4;
  localparam int FRAMES_KIND1 = 4;
  localparam int FRAME_MS     = 150;

  // time_ms / FRAME_MS as ((time_ms >> 1) * FRAME_RECIP) >> FRAME_SHIFT, exact for 32-bit time
  localparam int          FRAME_SHIFT = 38;
  localparam logic [31:0] FRAME_RECIP = 32'((64'd1 << FRAME_SHIFT) / (FRAME_MS / 2) + 1);

  // divider operand widths
  localparam int NUM_W = 54;
  localparam int DEN_W = 33;
  localparam int MAG_W = DEN_W - 1;
  localparam int CNT_W = $clog2(NUM_W - 1);

  typedef enum logic [2:0] {
    REG_PLAYER_X      = 3'd0,
    REG_PLAYER_Y      = 3'd1,
    REG_DIR_X         = 3'd2,
    REG_DIR_Y         = 3'd3,
    REG_PLANE_X       = 3'd4,
    REG_PLANE_Y       = 3'd5,
    REG_SCREEN_WIDTH  = 3'd6,
    REG_SCREEN_HEIGHT = 3'd7
  } reg_idx_t;

  typedef enum logic {
    OP_SETUP = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] sprite_x;
    logic signed [31:0] sprite_y;
    logic               sprite_kind;
    logic [31:0]        time_ms;
    logic [11:0]        column;
    logic [11:0]        row;
    logic [31:0]        wall_distance;
  } item_t;

  typedef struct packed {
    logic signed [31:0] player_x;
    logic signed [31:0] player_y;
    logic signed [18:0] dir_x;
    logic signed [18:0] dir_y;
    logic signed [18:0] plane_x;
    logic signed [18:0] plane_y;
    logic [12:0]        screen_width;
    logic [12:0]        screen_height;
  } cfg_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [NUM_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_F1,
    ST_DET_A, ST_DET_B, ST_NTX_A, ST_NTX_B, ST_NDP_A, ST_NDP_B, ST_NDP_C,
    ST_DTX, ST_DDP, ST_DSZ, ST_CM, ST_CS, ST_DCT, ST_BND,
    ST_P0, ST_PDX, ST_PDY, ST_OUT
  } bst_t;

  // screen dimension clamped to 1..4096
  function automatic logic [12:0] screen_dim(input logic [12:0] r);
    if (r == 13'd0) return 13'd1;
    else if (r > 13'd4096) return 13'd4096;
    else return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [NUM_W-1:0] v);
    if (v > $signed({{(NUM_W-32){1'b0}}, 32'h7FFF_FFFF})) return 32'sh7FFF_FFFF;
    else if (v < $signed({{(NUM_W-32){1'b1}}, 32'h8000_0000})) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [NUM_W-1:0] v);
    if (v > $signed({{(NUM_W-18){1'b0}}, 18'h1FFFF})) return 18'sh1FFFF;
    else if (v < $signed({{(NUM_W-18){1'b1}}, 18'h20000})) return 18'sh20000;
    else return v[17:0];
  endfunction

endpackage

// ----- rtl/bsp_front.sv -----
`timescale 1ns / 1ps
module bsp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic signed [31:0]  in_sprite_x,
  input  logic signed [31:0]  in_sprite_y,
  input  logic                in_sprite_kind,
  input  logic [31:0]         in_time_ms,
  input  logic [11:0]         in_column,
  input  logic [11:0]         in_row,
  input  logic [31:0]         in_wall_distance,
  output logic                q_valid,
  output bsp_pkg::item_t      q_item,
  input  logic                q_pop
);

  bsp_pkg::item_t mem_r [2];
  bsp_pkg::item_t item;
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     cnt_r;
  logic           push;

  // classify the request by opcode and pack it
  always_comb begin
    item.op            = bsp_pkg::op_t'(in_opcode);
    item.sprite_x      = in_sprite_x;
    item.sprite_y      = in_sprite_y;
    item.sprite_kind   = in_sprite_kind;
    item.time_ms       = in_time_ms;
    item.column        = in_column;
    item.row           = in_row;
    item.wall_distance = in_wall_distance;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  // two-entry queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= item;
  end

endmodule

// ----- rtl/bsp_div.sv -----
`timescale 1ns / 1ps
module bsp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  bsp_pkg::div_req_t  req,
  output bsp_pkg::div_rsp_t  rsp
);

  logic [bsp_pkg::NUM_W-2:0]   q_r;
  logic [bsp_pkg::MAG_W-1:0]   r_r;
  logic [bsp_pkg::MAG_W-1:0]   d_r;
  logic                        neg_r;
  logic [bsp_pkg::CNT_W-1:0]   cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic signed [bsp_pkg::NUM_W-1:0] num_abs;
  logic signed [bsp_pkg::DEN_W-1:0] den_abs;
  logic [bsp_pkg::MAG_W:0]     shl;
  logic [bsp_pkg::MAG_W:0]     diff;
  logic                        ge;

  // operand magnitudes
  assign num_abs = req.num[bsp_pkg::NUM_W-1] ? -req.num : req.num;
  assign den_abs = req.den[bsp_pkg::DEN_W-1] ? -req.den : req.den;

  // one restoring step per cycle
  assign shl  = {r_r, q_r[bsp_pkg::NUM_W-2]};
  assign diff = shl - {1'b0, d_r};
  assign ge   = !diff[bsp_pkg::MAG_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == bsp_pkg::CNT_W'(bsp_pkg::NUM_W - 2)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= num_abs[bsp_pkg::NUM_W-2:0];
      r_r   <= '0;
      d_r   <= den_abs[bsp_pkg::MAG_W-1:0];
      neg_r <= req.num[bsp_pkg::NUM_W-1] ^ req.den[bsp_pkg::DEN_W-1];
    end else if (busy_r) begin
      q_r <= {q_r[bsp_pkg::NUM_W-3:0], ge};
      r_r <= ge ? diff[bsp_pkg::MAG_W-1:0] : shl[bsp_pkg::MAG_W-1:0];
    end
  end

  // truncating signed quotient
  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule

// ----- rtl/bsp_back.sv -----
`timescale 1ns / 1ps
module bsp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bsp_pkg::cfg_t       cfg,
  input  logic                q_valid,
  input  bsp_pkg::item_t      q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_in_front,
  output logic signed [16:0]  out_start_x,
  output logic signed [16:0]  out_end_x,
  output logic [11:0]         out_start_y,
  output logic [11:0]         out_end_y,
  output logic [3:0]          out_frame,
  output logic [7:0]          out_texel_x,
  output logic [7:0]          out_texel_y,
  output logic                out_draw
);

  localparam int NW = bsp_pkg::NUM_W;
  localparam int DW = bsp_pkg::DEN_W;

  bsp_pkg::bst_t     state_r, state_nxt;
  bsp_pkg::div_req_t div_req;
  bsp_pkg::div_rsp_t div_rsp;
  bsp_pkg::item_t    it_r;

  // sprite state
  logic               valid_r;
  logic signed [31:0] depth_r;
  logic signed [17:0] center_r;
  logic [15:0]        size_r;
  logic signed [16:0] sx0_r, ex0_r;
  logic [11:0]        sy0_r, ey0_r;
  logic [3:0]         frame_r;

  // working registers
  logic signed [51:0] prod_r, t0_r;
  logic signed [36:0] det_r, ntx_r, nd_r;
  logic signed [31:0] tx_r;
  logic               inx_r;
  logic [7:0]         qx_r;
  logic [7:0]         tx8_r, ty8_r;
  logic               draw_r;
  logic               out_valid_r;

  logic signed [18:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [51:0] prod;
  logic signed [52:0] diff;
  logic [12:0]        sw, sh;
  logic signed [32:0] sx, sy, dpt;
  logic signed [31:0] dep_new;
  logic [14:0]        half;
  logic signed [19:0] px_off;
  logic signed [25:0] dv;
  logic signed [NW-1:0] numx, numy;
  logic [62:0]        t_prod;
  logic [24:0]        t_q;
  logic [3:0]         frame_c;
  logic               iny, inrange, ok;
  logic signed [16:0] sx0_c, ex0_c;
  logic [11:0]        sy0_c, ey0_c;
  logic signed [16:0] sy_t;
  logic [16:0]        ey_t;
  logic signed [18:0] sxl, exl;
  logic               load_out;

  bsp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // operands shared by the sequencer
  assign sw      = bsp_pkg::screen_dim(cfg.screen_width);
  assign sh      = bsp_pkg::screen_dim(cfg.screen_height);
  assign sx      = $signed({it_r.sprite_x[31], it_r.sprite_x})
                 - $signed({cfg.player_x[31], cfg.player_x});
  assign sy      = $signed({it_r.sprite_y[31], it_r.sprite_y})
                 - $signed({cfg.player_y[31], cfg.player_y});
  assign dpt     = $signed({depth_r[31], depth_r}) + $signed({tx_r[31], tx_r});
  assign prod    = mul_a * mul_b;
  assign diff    = $signed({t0_r[51], t0_r}) - $signed({prod_r[51], prod_r});
  assign dep_new = bsp_pkg::sat32(div_rsp.quo);
  assign half    = size_r[15:1];
  assign px_off  = $signed({8'b0, it_r.column}) - $signed({{2{center_r[17]}}, center_r})
                 + $signed({5'b0, half});
  assign numx    = NW'(px_off) * NW'(bsp_pkg::TEX_W);
  assign dv      = $signed({6'b0, it_r.row, 8'b0}) - $signed({6'b0, sh, 7'b0})
                 + $signed({3'b0, size_r, 7'b0});
  assign numy    = NW'(dv) * NW'(bsp_pkg::TEX_H);

  // animation frame by reciprocal multiplication
  assign t_prod  = 63'(it_r.time_ms[31:1]) * 63'(bsp_pkg::FRAME_RECIP);
  assign t_q     = t_prod[62:bsp_pkg::FRAME_SHIFT];
  assign frame_c = it_r.sprite_kind ? 4'(t_q % bsp_pkg::FRAMES_KIND1)
                                    : 4'(t_q % bsp_pkg::FRAMES_KIND0);

  // draw bounds from center and size
  always_comb begin
    sy_t  = $signed({5'b0, sh[12:1]}) - $signed({2'b0, half});
    sy0_c = (sy_t < 0) ? 12'd0 : sy_t[11:0];
    ey_t  = {5'b0, sh[12:1]} + {2'b0, half};
    ey0_c = (ey_t >= {4'b0, sh}) ? 12'(sh - 13'd1) : ey_t[11:0];
    sxl   = $signed({center_r[17], center_r}) - $signed({4'b0, half});
    if (sxl < 0) sx0_c = 17'sd0;
    else if (sxl > 19'sd65535) sx0_c = 17'sd65535;
    else sx0_c = sxl[16:0];
    exl   = $signed({center_r[17], center_r}) + $signed({4'b0, half});
    if (exl >= $signed({6'b0, sw})) exl = $signed({6'b0, sw}) - 19'sd1;
    if (exl < -19'sd65536) ex0_c = -17'sd65536;
    else ex0_c = exl[16:0];
  end

  // pixel tests
  always_comb begin
    iny     = (div_rsp.quo >= 0) && (div_rsp.quo < NW'(bsp_pkg::TEX_H));
    inrange = inx_r && iny;
    ok      = inrange && (depth_r > 0) && ($unsigned(depth_r) < it_r.wall_distance)
           && ($signed({6'b0, it_r.column}) >= $signed({sx0_r[16], sx0_r}))
           && ($signed({6'b0, it_r.column}) < $signed({ex0_r[16], ex0_r}))
           && (it_r.column != 12'd0) && ({1'b0, it_r.column} < sw)
           && (it_r.row >= sy0_r) && (it_r.row < ey0_r);
  end

  assign load_out = (state_r == bsp_pkg::ST_OUT) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bsp_pkg::ST_IDLE:
        if (q_valid) state_nxt = (q_item.op == bsp_pkg::OP_SETUP) ? bsp_pkg::ST_F1
                                                                  : bsp_pkg::ST_P0;
      bsp_pkg::ST_F1:    state_nxt = bsp_pkg::ST_DET_A;
      bsp_pkg::ST_DET_A: state_nxt = bsp_pkg::ST_DET_B;
      bsp_pkg::ST_DET_B: state_nxt = bsp_pkg::ST_NTX_A;
      bsp_pkg::ST_NTX_A: state_nxt = bsp_pkg::ST_NTX_B;
      bsp_pkg::ST_NTX_B: state_nxt = bsp_pkg::ST_NDP_A;
      bsp_pkg::ST_NDP_A: state_nxt = bsp_pkg::ST_NDP_B;
      bsp_pkg::ST_NDP_B: state_nxt = bsp_pkg::ST_NDP_C;
      bsp_pkg::ST_NDP_C: state_nxt = (det_r == 0) ? bsp_pkg::ST_OUT : bsp_pkg::ST_DTX;
      bsp_pkg::ST_DTX:   if (div_rsp.done) state_nxt = bsp_pkg::ST_DDP;
      bsp_pkg::ST_DDP:
        if (div_rsp.done) state_nxt = (dep_new > 0) ? bsp_pkg::ST_DSZ : bsp_pkg::ST_OUT;
      bsp_pkg::ST_DSZ:   if (div_rsp.done) state_nxt = bsp_pkg::ST_CM;
      bsp_pkg::ST_CM:    state_nxt = bsp_pkg::ST_CS;
      bsp_pkg::ST_CS:    state_nxt = bsp_pkg::ST_DCT;
      bsp_pkg::ST_DCT:   if (div_rsp.done) state_nxt = bsp_pkg::ST_BND;
      bsp_pkg::ST_BND:   state_nxt = bsp_pkg::ST_OUT;
      bsp_pkg::ST_P0:
        state_nxt = (!valid_r || size_r == 16'd0) ? bsp_pkg::ST_OUT : bsp_pkg::ST_PDX;
      bsp_pkg::ST_PDX:   if (div_rsp.done) state_nxt = bsp_pkg::ST_PDY;
      bsp_pkg::ST_PDY:   if (div_rsp.done) state_nxt = bsp_pkg::ST_OUT;
      bsp_pkg::ST_OUT:   if (load_out) state_nxt = bsp_pkg::ST_IDLE;
      default:           state_nxt = bsp_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: queue pop, multiplier and divider operands
  always_comb begin
    q_pop         = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    unique case (state_r)
      bsp_pkg::ST_IDLE: q_pop = q_valid;
      bsp_pkg::ST_DET_A: begin mul_a = cfg.plane_x; mul_b = 33'(cfg.dir_y); end
      bsp_pkg::ST_DET_B: begin mul_a = cfg.dir_x;   mul_b = 33'(cfg.plane_y); end
      bsp_pkg::ST_NTX_A: begin mul_a = cfg.dir_y;   mul_b = sx; end
      bsp_pkg::ST_NTX_B: begin mul_a = cfg.dir_x;   mul_b = sy; end
      bsp_pkg::ST_NDP_A: begin mul_a = cfg.plane_x; mul_b = sy; end
      bsp_pkg::ST_NDP_B: begin mul_a = cfg.plane_y; mul_b = sx; end
      bsp_pkg::ST_NDP_C: begin
        div_req.start = (det_r != 0);
        div_req.num   = $signed({ntx_r[36], ntx_r, 16'b0});
        div_req.den   = det_r[DW-1:0];
      end
      bsp_pkg::ST_DTX: begin
        div_req.start = div_rsp.done;
        div_req.num   = $signed({nd_r[36], nd_r, 16'b0});
        div_req.den   = det_r[DW-1:0];
      end
      bsp_pkg::ST_DDP: begin
        div_req.start = div_rsp.done && (dep_new > 0);
        div_req.num   = $signed({{(NW-29){1'b0}}, sh, 16'b0});
        div_req.den   = $signed({1'b0, dep_new});
      end
      bsp_pkg::ST_CM: begin mul_a = $signed({7'b0, sw[12:1]}); mul_b = dpt; end
      bsp_pkg::ST_CS: begin
        div_req.start = 1'b1;
        div_req.num   = NW'(prod_r);
        div_req.den   = $signed({1'b0, depth_r});
      end
      bsp_pkg::ST_P0: begin
        div_req.start = valid_r && (size_r != 16'd0);
        div_req.num   = numx;
        div_req.den   = $signed({17'b0, size_r});
      end
      bsp_pkg::ST_PDX: begin
        div_req.start = div_rsp.done;
        div_req.num   = numy;
        div_req.den   = $signed({9'b0, size_r, 8'b0});
      end
      default: begin
      end
    endcase
  end

  // control and sprite state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= 1'b0;
      depth_r     <= '0;
      center_r    <= '0;
      size_r      <= '0;
      sx0_r       <= '0;
      ex0_r       <= '0;
      sy0_r       <= '0;
      ey0_r       <= '0;
      frame_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      // new setup clears the sprite before the math
      if (state_r == bsp_pkg::ST_IDLE && q_valid && q_item.op == bsp_pkg::OP_SETUP) begin
        valid_r  <= 1'b0;
        depth_r  <= '0;
        center_r <= '0;
        size_r   <= '0;
        sx0_r    <= '0;
        ex0_r    <= '0;
        sy0_r    <= '0;
        ey0_r    <= '0;
      end
      if (state_r == bsp_pkg::ST_F1) frame_r <= frame_c;
      if (state_r == bsp_pkg::ST_DDP && div_rsp.done) depth_r <= dep_new;
      if (state_r == bsp_pkg::ST_DSZ && div_rsp.done)
        size_r <= (div_rsp.quo > NW'(65535)) ? 16'hFFFF : div_rsp.quo[15:0];
      if (state_r == bsp_pkg::ST_DCT && div_rsp.done) center_r <= bsp_pkg::sat18(div_rsp.quo);
      if (state_r == bsp_pkg::ST_BND) begin
        valid_r <= 1'b1;
        sx0_r   <= sx0_c;
        ex0_r   <= ex0_c;
        sy0_r   <= sy0_c;
        ey0_r   <= ey0_c;
      end
    end
  end

  // datapath and result registers
  always_ff @(posedge clk) begin
    prod_r <= prod;
    if (state_r == bsp_pkg::ST_IDLE && q_valid) begin
      it_r   <= q_item;
      tx8_r  <= '0;
      ty8_r  <= '0;
      draw_r <= 1'b0;
    end
    if (state_r == bsp_pkg::ST_DET_B || state_r == bsp_pkg::ST_NTX_B ||
        state_r == bsp_pkg::ST_NDP_B) t0_r <= prod_r;
    if (state_r == bsp_pkg::ST_NTX_A) det_r <= diff[52:16];
    if (state_r == bsp_pkg::ST_NDP_A) ntx_r <= diff[52:16];
    if (state_r == bsp_pkg::ST_NDP_C) nd_r  <= diff[52:16];
    if (state_r == bsp_pkg::ST_DTX && div_rsp.done) tx_r <= dep_new;
    if (state_r == bsp_pkg::ST_PDX && div_rsp.done) begin
      inx_r <= (div_rsp.quo >= 0) && (div_rsp.quo < NW'(bsp_pkg::TEX_W));
      qx_r  <= div_rsp.quo[7:0];
    end
    if (state_r == bsp_pkg::ST_PDY && div_rsp.done) begin
      tx8_r  <= inrange ? qx_r : 8'd0;
      ty8_r  <= inrange ? div_rsp.quo[7:0] : 8'd0;
      draw_r <= ok;
    end
    if (load_out) begin
      out_in_front <= valid_r;
      out_start_x  <= sx0_r;
      out_end_x    <= ex0_r;
      out_start_y  <= sy0_r;
      out_end_y    <= ey0_r;
      out_frame    <= frame_r;
      out_texel_x  <= tx8_r;
      out_texel_y  <= ty8_r;
      out_draw     <= draw_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/billboard_sprite_projection.sv -----
`timescale 1ns / 1ps
// divider use: a setup request runs four divisions and a pixel request two, all on the
// one-bit-per-cycle shared divider; a sprite behind the camera or a singular camera
// finishes sooner
// throughput: one request at a time in the back end; a two-entry queue keeps
// taking requests while the back end works or a result waits, until it is full
// reset: synchronous active-low rst_n restores register defaults and clears sprite state
`include "billboard_sprite_projection_defines.svh"
module billboard_sprite_projection (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic signed [31:0]  in_sprite_x,
  input  logic signed [31:0]  in_sprite_y,
  input  logic                in_sprite_kind,
  input  logic [31:0]         in_time_ms,
  input  logic [11:0]         in_column,
  input  logic [11:0]         in_row,
  input  logic [31:0]         in_wall_distance,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_in_front,
  output logic signed [16:0]  out_start_x,
  output logic signed [16:0]  out_end_x,
  output logic [11:0]         out_start_y,
  output logic [11:0]         out_end_y,
  output logic [3:0]          out_frame,
  output logic [7:0]          out_texel_x,
  output logic [7:0]          out_texel_y,
  output logic                out_draw
);

  bsp_pkg::cfg_t  cfg_r;
  bsp_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  assign cfg_ready = 1'b1;

  // camera and screen registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.player_x      <= '0;
      cfg_r.player_y      <= '0;
      cfg_r.dir_x         <= 19'sd65536;
      cfg_r.dir_y         <= '0;
      cfg_r.plane_x       <= '0;
      cfg_r.plane_y       <= 19'sd43254;
      cfg_r.screen_width  <= 13'd640;
      cfg_r.screen_height <= 13'd480;
    end else if (cfg_valid) begin
      unique case (bsp_pkg::reg_idx_t'(cfg_index))
        bsp_pkg::REG_PLAYER_X:      cfg_r.player_x      <= cfg_data;
        bsp_pkg::REG_PLAYER_Y:      cfg_r.player_y      <= cfg_data;
        bsp_pkg::REG_DIR_X:         cfg_r.dir_x         <= cfg_data[18:0];
        bsp_pkg::REG_DIR_Y:         cfg_r.dir_y         <= cfg_data[18:0];
        bsp_pkg::REG_PLANE_X:       cfg_r.plane_x       <= cfg_data[18:0];
        bsp_pkg::REG_PLANE_Y:       cfg_r.plane_y       <= cfg_data[18:0];
        bsp_pkg::REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_data[12:0];
        bsp_pkg::REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  bsp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_sprite_x      (in_sprite_x),
    .in_sprite_y      (in_sprite_y),
    .in_sprite_kind   (in_sprite_kind),
    .in_time_ms       (in_time_ms),
    .in_column        (in_column),
    .in_row           (in_row),
    .in_wall_distance (in_wall_distance),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  bsp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_in_front (out_in_front),
    .out_start_x  (out_start_x),
    .out_end_x    (out_end_x),
    .out_start_y  (out_start_y),
    .out_end_y    (out_end_y),
    .out_frame    (out_frame),
    .out_texel_x  (out_texel_x),
    .out_texel_y  (out_texel_y),
    .out_draw     (out_draw)
  );

  // checks
  `BSP_ASSERT(a_pop_needs_item, clk, rst_n, q_pop |-> q_valid, "pop from empty queue")
  `BSP_ASSERT(a_draw_in_front, clk, rst_n, out_valid && out_draw |-> out_in_front, "no sprite")
  `BSP_ASSERT(a_draw_texel, clk, rst_n, out_valid && out_draw |-> out_texel_x < 8'd64, "texel")

endmodule
